@@ src/sba_pkg.sv @@
package sba_pkg;

  localparam int OP_W    = 2;
  localparam int STAGE_W = 4;
  localparam int EST_W   = 24;
  localparam int AGE_W   = 16;
  localparam int CNT_W   = 16;
  localparam int USED_W  = 32;
  localparam int SCNT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [EST_W-1:0]  FALLBACK_EST = 24'd10;
  localparam logic [EST_W-1:0]  EST_FLOOR    = 24'd10;
  localparam logic [SCNT_W-1:0] FAST_SAMPLES = 3'd4;
  localparam logic [SCNT_W-1:0] SAMPLE_MAX   = 3'd7;
  localparam logic [CNT_W-1:0]  CNT_MAX      = '1;
  localparam logic [USED_W-1:0] USED_MAX     = '1;

  // floor(x / 5) = (x * DIV5_MUL) >> DIV5_SHIFT for x below 2**30
  localparam int SUM5_W     = EST_W + 3;
  localparam int DIV5_MUL_W = 28;
  localparam int PROD5_W    = SUM5_W + DIV5_MUL_W;
  localparam int DIV5_SHIFT = 30;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 28'd214748365;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 2'd0,
    OP_BEGIN    = 2'd1,
    OP_COMPLETE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOADING  = 2'd0,
    CFG_BUDGET   = 2'd1,
    CFG_DEADLINE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic               start;
    logic               begin_req;
    logic               grant;
    logic               promote;
    logic               complete;
    logic               overrun;
    logic [STAGE_W-1:0] stage;
    logic [EST_W-1:0]   actual;
  } sba_evt_t;

  typedef struct packed {
    logic [CNT_W-1:0]   attempted;
    logic [CNT_W-1:0]   deferred;
    logic [CNT_W-1:0]   promoted;
    logic [CNT_W-1:0]   completed;
    logic [CNT_W-1:0]   overruns;
    logic [USED_W-1:0]  used;
    logic [EST_W-1:0]   longest;
    logic [STAGE_W-1:0] longest_stage;
  } sba_stats_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
  endfunction

  function automatic logic [EST_W-1:0] default_est(input logic [STAGE_W-1:0] s);
    logic [EST_W-1:0] e;
    case (s)
      4'd0:    e = 24'd500;
      4'd1:    e = 24'd200;
      4'd2:    e = 24'd250;
      4'd3:    e = 24'd750;
      4'd4:    e = 24'd200;
      4'd5:    e = 24'd30;
      4'd6:    e = 24'd1500;
      4'd7:    e = 24'd30;
      4'd8:    e = 24'd200;
      4'd9:    e = 24'd50;
      default: e = FALLBACK_EST;
    endcase
    return e;
  endfunction

endpackage

@@ src/sba_in_if.sv @@
interface sba_in_if import sba_pkg::*;;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [STAGE_W-1:0] stage;
  logic [EST_W-1:0]   elapsed_time;
  logic               visible_required;
  logic [AGE_W-1:0]   age_frames;
  logic [EST_W-1:0]   actual_time;

  modport source (
    output valid, operation, stage, elapsed_time, visible_required, age_frames,
           actual_time,
    input  ready
  );
  modport sink (
    input  valid, operation, stage, elapsed_time, visible_required, age_frames,
           actual_time,
    output ready
  );
endinterface

@@ src/sba_out_if.sv @@
interface sba_out_if import sba_pkg::*;;
  logic               valid;
  logic               ready;
  logic               granted;
  logic               promoted;
  logic [CNT_W-1:0]   attempted_count;
  logic [CNT_W-1:0]   deferred_count;
  logic [CNT_W-1:0]   promotion_count;
  logic [CNT_W-1:0]   completed_count;
  logic [CNT_W-1:0]   overrun_count;
  logic [USED_W-1:0]  used_time;
  logic [EST_W-1:0]   longest_time;
  logic [STAGE_W-1:0] longest_stage;
  logic [EST_W-1:0]   stage_estimate;

  modport source (
    output valid, granted, promoted, attempted_count, deferred_count,
           promotion_count, completed_count, overrun_count, used_time,
           longest_time, longest_stage, stage_estimate,
    input  ready
  );
  modport sink (
    input  valid, granted, promoted, attempted_count, deferred_count,
           promotion_count, completed_count, overrun_count, used_time,
           longest_time, longest_stage, stage_estimate,
    output ready
  );
endinterface

@@ src/sba_est_table.sv @@
module sba_est_table import sba_pkg::*; #(
  parameter int STAGE_COUNT = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd,
  input  logic [STAGE_W-1:0] stage,
  input  logic [EST_W-1:0]   actual,
  output logic               in_range,
  output logic [EST_W-1:0]   est_cur,
  output logic [EST_W-1:0]   est_nxt
);

  localparam int IdxW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;

  logic [EST_W-1:0]  est_r [STAGE_COUNT];
  logic [SCNT_W-1:0] cnt_r [STAGE_COUNT];

  logic [IdxW-1:0]    idx;
  logic [EST_W-1:0]   est_rd;
  logic [SCNT_W-1:0]  cnt_rd;
  logic [EST_W:0]     sum2;
  logic [SUM5_W-1:0]  sum5;
  logic [PROD5_W-1:0] prod5;
  logic [EST_W-1:0]   blend;

  assign in_range = {1'b0, stage} < (STAGE_W + 1)'(STAGE_COUNT);
  assign idx      = in_range ? stage[IdxW-1:0] : '0;
  assign est_rd   = est_r[idx];
  assign cnt_rd   = cnt_r[idx];
  assign est_cur  = in_range ? est_rd : FALLBACK_EST;

  // fast blend: mean; slow blend: (4 est + actual) / 5
  assign sum2  = {1'b0, est_rd} + {1'b0, actual};
  assign sum5  = {1'b0, est_rd, 2'b00} + SUM5_W'(actual);
  assign prod5 = PROD5_W'(sum5) * PROD5_W'(DIV5_MUL);

  always_comb begin
    if (cnt_rd < FAST_SAMPLES) begin
      blend = sum2[EST_W:1];
    end else begin
      blend = prod5[DIV5_SHIFT +: EST_W];
    end
    est_nxt = (blend < EST_FLOOR) ? EST_FLOOR : blend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGE_COUNT; i++) begin
        est_r[i] <= default_est(STAGE_W'(i));
        cnt_r[i] <= '0;
      end
    end else if (upd) begin
      est_r[idx] <= est_nxt;
      if (cnt_rd != SAMPLE_MAX) begin
        cnt_r[idx] <= cnt_rd + 1'b1;
      end
    end
  end

endmodule

@@ src/sba_stats.sv @@
module sba_stats import sba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  sba_evt_t   evt,
  output sba_stats_t stats_nxt
);

  sba_stats_t        stats_r;
  logic [USED_W:0]   used_sum;

  assign used_sum = {1'b0, stats_r.used} + (USED_W + 1)'(evt.actual);

  always_comb begin
    stats_nxt = stats_r;
    if (evt.start) begin
      stats_nxt = '0;
    end else if (evt.begin_req) begin
      stats_nxt.attempted = sat_inc(stats_r.attempted);
      if (evt.promote) begin
        stats_nxt.promoted = sat_inc(stats_r.promoted);
      end else if (!evt.grant) begin
        stats_nxt.deferred = sat_inc(stats_r.deferred);
      end
    end else if (evt.complete) begin
      stats_nxt.completed = sat_inc(stats_r.completed);
      stats_nxt.used      = used_sum[USED_W] ? USED_MAX : used_sum[USED_W-1:0];
      if (evt.actual > stats_r.longest) begin
        stats_nxt.longest       = evt.actual;
        stats_nxt.longest_stage = evt.stage;
      end
      if (evt.overrun) begin
        stats_nxt.overruns = sat_inc(stats_r.overruns);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stats_r <= '0;
    end else if (en) begin
      stats_r <= stats_nxt;
    end
  end

endmodule

@@ src/stage_budget_admission_unit.sv @@
// channel  | dir | payload
// in_ch    | in  | operation, stage, elapsed_time, visible_required, age_frames, actual_time
// out_ch   | out | granted, promoted, five counters, used_time, longest_*, stage_estimate
// cfg_*    | in  | cfg_we, cfg_index, cfg_data (loading_mode, budget_time, deadline_frames)
//
// one word per cycle sustained while out_ch.ready is high;
// the table lookup, budget compare and divide-by-five multiply sit between the
// input register and the result register
// synchronous active-low reset restores the default estimates and clears the counters
// a stalled output holds the result; the input register still takes a word if empty
module stage_budget_admission_unit import sba_pkg::*; #(
  parameter int STAGE_COUNT = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sba_in_if.sink                in_ch,
  sba_out_if.source             out_ch
);

  logic               loading_r;
  logic [EST_W-1:0]   budget_r;
  logic [AGE_W-1:0]   deadline_r;

  logic               in_vld_r;
  logic [OP_W-1:0]    op_r;
  logic [STAGE_W-1:0] stage_r;
  logic [EST_W-1:0]   elapsed_r;
  logic               visible_r;
  logic [AGE_W-1:0]   age_r;
  logic [EST_W-1:0]   actual_r;

  logic               out_vld_r;
  logic               granted_r;
  logic               promoted_r;
  sba_stats_t         stats_out_r;
  logic [EST_W-1:0]   est_out_r;

  logic               adv;
  logic               in_fire;
  op_t                op;
  logic               in_range;
  logic [EST_W-1:0]   est_cur;
  logic [EST_W-1:0]   est_nxt;
  logic [EST_W:0]     need;
  logic               fits;
  logic               promote_ok;
  sba_evt_t           evt;
  sba_stats_t         stats_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loading_r  <= 1'b0;
      budget_r   <= '0;
      deadline_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOADING:  loading_r  <= cfg_data[0];
        CFG_BUDGET:   budget_r   <= cfg_data[EST_W-1:0];
        CFG_DEADLINE: deadline_r <= cfg_data[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r      <= in_ch.operation;
      stage_r   <= in_ch.stage;
      elapsed_r <= in_ch.elapsed_time;
      visible_r <= in_ch.visible_required;
      age_r     <= in_ch.age_frames;
      actual_r  <= in_ch.actual_time;
    end
  end

  assign op = op_t'(op_r);

  sba_est_table #(
    .STAGE_COUNT (STAGE_COUNT)
  ) u_est (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (adv && evt.complete),
    .stage    (stage_r),
    .actual   (actual_r),
    .in_range (in_range),
    .est_cur  (est_cur),
    .est_nxt  (est_nxt)
  );

  assign need       = {1'b0, elapsed_r} + {1'b0, est_cur};
  assign fits       = loading_r || (budget_r == '0) || (need <= {1'b0, budget_r});
  assign promote_ok = visible_r && (deadline_r != '0) && (age_r >= deadline_r);

  always_comb begin
    evt          = '0;
    evt.stage    = stage_r;
    evt.actual   = actual_r;
    evt.overrun  = actual_r > est_cur;
    case (op)
      OP_START:    evt.start     = 1'b1;
      OP_BEGIN:    begin
        evt.begin_req = 1'b1;
        evt.grant     = fits || promote_ok;
        evt.promote   = !fits && promote_ok;
      end
      OP_COMPLETE: evt.complete  = in_range;
      default: ;
    endcase
  end

  sba_stats u_stats (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .evt       (evt),
    .stats_nxt (stats_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      granted_r   <= evt.grant;
      promoted_r  <= evt.promote;
      stats_out_r <= stats_nxt;
      est_out_r   <= evt.complete ? est_nxt : est_cur;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.granted         = granted_r;
  assign out_ch.promoted        = promoted_r;
  assign out_ch.attempted_count = stats_out_r.attempted;
  assign out_ch.deferred_count  = stats_out_r.deferred;
  assign out_ch.promotion_count = stats_out_r.promoted;
  assign out_ch.completed_count = stats_out_r.completed;
  assign out_ch.overrun_count   = stats_out_r.overruns;
  assign out_ch.used_time       = stats_out_r.used;
  assign out_ch.longest_time    = stats_out_r.longest;
  assign out_ch.longest_stage   = stats_out_r.longest_stage;
  assign out_ch.stage_estimate  = est_out_r;

  a_promote_granted: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && promoted_r |-> granted_r)
    else $error("promoted word without grant");

  a_deferred_le_attempted: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (stats_out_r.deferred <= stats_out_r.attempted) &&
                  (stats_out_r.promoted <= stats_out_r.attempted))
    else $error("refusal or promotion count above attempt count");

  a_estimate_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> est_out_r >= EST_FLOOR)
    else $error("stage estimate below floor");

  a_longest_in_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> USED_W'(stats_out_r.longest) <= stats_out_r.used)
    else $error("longest stage exceeds used time");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(op_r) && $stable(stage_r) &&
                         $stable(actual_r))
    else $error("held input word changed");

endmodule
